// File: hw/rtl/slt_pkg.sv
// Shared types, character codes and helper functions for the line tokenizer.
package slt_pkg;

    // Tokenizer phase
    typedef enum logic [2:0] {
        PH_BETWEEN = 3'd0,
        PH_TOKEN   = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_HEX_HI  = 3'd3,
        PH_HEX_LO  = 3'd4
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Line status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_UNCLOSED = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [6:0] LIMIT_RESET = 7'd16;
    localparam int         MAX_RESULTS = 4;

    // Tokenizer state carried from item to item
    typedef struct packed {
        t_phase      phase;
        logic        inq;
        logic [7:0]  held;
        logic [6:0]  ts;
    } t_state;

    // One result item, without its last flag
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [5:0] slot;
        logic [6:0] total;
        logic       status;
    } t_result;

    // All results caused by one input item
    typedef struct packed {
        logic [2:0]                   count;
        t_result [MAX_RESULTS-1:0]    res;
    } t_bundle;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Returns {valid, value} of a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                return {1'b1, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
                return {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

    // Build one result; slot is the index of the current token
    function automatic t_result mk_result(input logic [1:0] kind, input logic [7:0] ch,
                                          input logic [6:0] ts, input logic [6:0] total,
                                          input logic status);
        t_result    r;
        logic [6:0] tm;
        begin
            tm       = ts - 7'd1;
            r.kind   = kind;
            r.ch     = ch;
            r.slot   = (kind != KIND_DONE && ts != 7'd0) ? tm[5:0] : 6'd0;
            r.total  = total;
            r.status = status;
            return r;
        end
    endfunction

endpackage

// File: hw/rtl/slt_core.sv
// Next-state and result logic of the tokenizer for one input byte.
module slt_core #(
    parameter int MAX_TOKEN_SLOTS = 64
) (
    input  logic [7:0]       i_char,
    input  logic [6:0]       i_limit,
    input  slt_pkg::t_state  i_state,
    output slt_pkg::t_state  o_state,
    output slt_pkg::t_bundle o_bundle
);
    import slt_pkg::*;

    localparam int         CAP     = (MAX_TOKEN_SLOTS > 127) ? 127 : MAX_TOKEN_SLOTS;
    localparam logic [6:0] CAP_LIM = CAP[6:0];

    t_phase     ph;
    logic       q;
    logic [7:0] held;
    logic [6:0] ts;
    logic [2:0] k;
    t_result [MAX_RESULTS-1:0] res;
    logic       do_tb;
    logic       do_done;
    logic       done_st;
    logic [6:0] lim;
    logic [4:0] hv_c;
    logic [4:0] hv_h;

    assign lim  = (i_limit > CAP_LIM) ? CAP_LIM : i_limit;
    assign hv_c = hex_val(i_char);
    assign hv_h = hex_val(i_state.held);

    // Walk one byte through the phase logic, collecting results in order
    always_comb begin
        ph      = i_state.phase;
        q       = i_state.inq;
        held    = i_state.held;
        ts      = i_state.ts;
        k       = 3'd0;
        res     = '0;
        do_tb   = 1'b0;
        do_done = 1'b0;
        done_st = STATUS_OK;

        case (i_state.phase)
            PH_BETWEEN: begin
                if (i_char == CH_NUL) begin
                    do_done = 1'b1;
                end else if (is_sep(i_char) || ts >= lim) begin
                    ph = PH_BETWEEN;
                end else begin
                    ts = ts + 7'd1;
                    if (i_char == CH_QUOTE) begin
                        q  = 1'b1;
                        ph = PH_TOKEN;
                    end else begin
                        q     = 1'b0;
                        do_tb = 1'b1;
                    end
                end
            end
            PH_ESCAPE: begin
                ph = PH_TOKEN;
                if (i_char == CH_NUL) begin
                    res[k[1:0]] = mk_result(KIND_BYTE, CH_BSL, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                    do_tb       = 1'b1;
                end else if (i_char == CH_X) begin
                    ph = PH_HEX_HI;
                end else if (i_char == CH_N) begin
                    res[k[1:0]] = mk_result(KIND_BYTE, CH_LF, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                end else if (i_char == CH_T) begin
                    res[k[1:0]] = mk_result(KIND_BYTE, CH_TAB, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                end else if (i_char == CH_R) begin
                    res[k[1:0]] = mk_result(KIND_BYTE, CH_CR, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                end else begin
                    res[k[1:0]] = mk_result(KIND_BYTE, i_char, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                end
            end
            PH_HEX_HI: begin
                if (hv_c[4]) begin
                    held = i_char;
                    ph   = PH_HEX_LO;
                end else begin
                    res[k[1:0]] = mk_result(KIND_BYTE, CH_X, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                    do_tb       = 1'b1;
                end
            end
            PH_HEX_LO: begin
                if (hv_c[4]) begin
                    res[k[1:0]] = mk_result(KIND_BYTE, {hv_h[3:0], hv_c[3:0]}, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                    held        = 8'd0;
                    ph          = PH_TOKEN;
                end else begin
                    res[k[1:0]] = mk_result(KIND_BYTE, CH_X, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                    res[k[1:0]] = mk_result(KIND_BYTE, held, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                    held        = 8'd0;
                    do_tb       = 1'b1;
                end
            end
            default: begin
                do_tb = 1'b1;
            end
        endcase

        // Ordinary byte inside a token
        if (do_tb) begin
            ph = PH_TOKEN;
            if (i_char == CH_NUL) begin
                do_done = 1'b1;
                if (q) begin
                    done_st = STATUS_UNCLOSED;
                end else begin
                    res[k[1:0]] = mk_result(KIND_END, 8'd0, ts, 7'd0, 1'b0);
                    k           = k + 3'd1;
                end
            end else if (i_char == CH_BSL) begin
                ph = PH_ESCAPE;
            end else if (q ? (i_char == CH_QUOTE) : is_sep(i_char)) begin
                res[k[1:0]] = mk_result(KIND_END, 8'd0, ts, 7'd0, 1'b0);
                k           = k + 3'd1;
                ph          = PH_BETWEEN;
                q           = 1'b0;
            end else begin
                res[k[1:0]] = mk_result(KIND_BYTE, i_char, ts, 7'd0, 1'b0);
                k           = k + 3'd1;
            end
        end

        // Close the line and return to the idle state
        if (do_done) begin
            res[k[1:0]] = mk_result(KIND_DONE, 8'd0, ts, ts, done_st);
            k           = k + 3'd1;
            ph          = PH_BETWEEN;
            q           = 1'b0;
            held        = 8'd0;
            ts          = 7'd0;
        end
    end

    assign o_state.phase  = ph;
    assign o_state.inq    = q;
    assign o_state.held   = held;
    assign o_state.ts     = ts;
    assign o_bundle.count = k;
    assign o_bundle.res   = res;

endmodule

// File: hw/rtl/shell_line_tokenizer.sv
// Top level of the streaming command line tokenizer.
//
// Input channel: one line byte per item on i_char_in (i_valid / o_stall); a
// zero byte ends the line. Output channel: result items (o_valid / i_stall),
// each a token byte, a token end or a line-done carrying the token count and
// status; o_last_of_run marks the final result of one input byte.
// Configuration: i_cfg_valid / o_cfg_ready write the 7-bit token limit
// (reset 16); o_cfg_ready is always high.
// A byte's results are registered into the result queue before they are offered.
// Throughput: one byte per cycle while each byte causes at most one result and
// the output is not stalled; a byte causing several results offers them one by one.
// A two-entry result queue lets the next byte enter while results still wait;
// o_stall rises only when both entries are occupied.
// Reset: tokenizer back between tokens, token count zero, queue empty,
// limit 16. A stalled output holds its result item unchanged.
module shell_line_tokenizer #(
    parameter int MAX_TOKEN_SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_char_out,
    output logic [5:0] o_token_slot,
    output logic [6:0] o_token_total,
    output logic       o_line_status,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);
    import slt_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_bundle    n_bundle;
    logic [6:0] r_limit;
    t_bundle    r_fifo [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    t_bundle    head;
    t_result    cur;
    logic       in_fire;
    logic       out_fire;
    logic       push;
    logic       pop;
    logic       last;

    slt_core #(
        .MAX_TOKEN_SLOTS(MAX_TOKEN_SLOTS)
    ) u_core (
        .i_char  (i_char_in),
        .i_limit (r_limit),
        .i_state (r_state),
        .o_state (n_state),
        .o_bundle(n_bundle)
    );

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_cnt == 2'd2);
    assign in_fire     = i_valid && !o_stall;
    assign o_valid     = (r_cnt != 2'd0);
    assign out_fire    = o_valid && !i_stall;
    assign push        = in_fire && (n_bundle.count != 3'd0);
    assign head        = r_fifo[r_rd];
    assign cur         = head.res[r_idx];
    assign last        = ({1'b0, r_idx} + 3'd1) == head.count;
    assign pop         = out_fire && last;

    // Drive result fields from the queue head
    assign o_result_kind = cur.kind;
    assign o_char_out    = cur.ch;
    assign o_token_slot  = cur.slot;
    assign o_token_total = cur.total;
    assign o_line_status = cur.status;
    assign o_last_of_run = last;

    // Hold the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // Advance tokenizer state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_BETWEEN, inq: 1'b0, held: 8'd0, ts: 7'd0};
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Store result bundles
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr] <= n_bundle;
        end
    end

    // Queue pointers, occupancy and result index within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (out_fire) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

endmodule

// File: hw/rtl/slt_checker.sv
// Port-level checks of the tokenizer, bound to the top level.
module slt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_result_kind,
    input logic [7:0] o_char_out,
    input logic [5:0] o_token_slot,
    input logic [6:0] o_token_total,
    input logic       o_line_status,
    input logic       o_last_of_run
);
    import slt_pkg::*;

    // Nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind) && $stable(o_char_out)
            && $stable(o_token_slot) && $stable(o_token_total)
            && $stable(o_line_status) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // A line-done result always closes the run of its byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_DONE |-> o_last_of_run)
        else $error("line done not last of run");

    // Only token bytes carry a character; totals only on line done
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_BYTE |-> o_char_out == 8'd0)
        else $error("character on a non-byte result");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_DONE |-> o_token_total == 7'd0
            && o_line_status == STATUS_OK && o_result_kind != 2'd3)
        else $error("bad fields on token result");

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_result_kind(o_result_kind),
    .o_char_out   (o_char_out),
    .o_token_slot (o_token_slot),
    .o_token_total(o_token_total),
    .o_line_status(o_line_status),
    .o_last_of_run(o_last_of_run)
);
